/* hw/rtl/msss_pkg.sv */
// ----------------------------------------------------------------------------
// msss_pkg
// Shared types and codes for the multi-stack shared store: request and
// response beats, configuration view, status and operation codes.
// ----------------------------------------------------------------------------
package msss_pkg;

   // Configuration port geometry: four 32-bit registers at 4-byte spacing
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register indexes (paddr[3:2])
   localparam logic [1:0] REG_STACK_COUNT = 2'd0;
   localparam logic [1:0] REG_SIZE_FIRST  = 2'd1;
   localparam logic [1:0] REG_SIZE_SECOND = 2'd2;
   localparam logic [1:0] REG_SIZE_THIRD  = 2'd3;

   // Reset values of the registers
   localparam logic [2:0] RST_STACK_COUNT = 3'd1;
   localparam logic [7:0] RST_SIZE        = 8'd32;

   // Stacks addressable by a request
   localparam int MAX_STACKS = 4;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_OVERFLOW  = 2'd1,
      STAT_UNDERFLOW = 2'd2,
      STAT_BAD_STACK = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      op_type             op;
      logic [1:0]         stack_sel;
      logic signed [31:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pop_value;
      status_type         status;
   } rsp_type;

   typedef struct packed {
      logic [2:0] stack_count;
      logic [7:0] size_first;
      logic [7:0] size_second;
      logic [7:0] size_third;
   } cfg_type;

endpackage

/* hw/rtl/multi_stack_shared_store_core.sv */
// ----------------------------------------------------------------------------
// multi_stack_shared_store_core
// Several stacks sharing one data memory; push and pop commands with
// overflow, underflow and bad-index status.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_payload and raise start; the command is
//   taken at a clock edge where start is high and busy is low.
//   Response channel: one beat per command, shown for exactly one cycle
//   with rsp_valid high. The receiver cannot stall; it must take the beat.
//   Sequence: at the accepting edge the command is registered and the
//   block enters the execute state. Its first cycle reads the stack fill
//   counter, checks the region bounds and issues the memory access; the
//   response beat is registered at its end, and the memory returns its
//   registered read data with that beat.
//   busy is high only in that first cycle, so a new command may be taken
//   while the previous response is on the output.
//   Configuration: APB-style port, four 32-bit registers at byte addresses
//   0, 4, 8, 12 (stack count, three region sizes). Write only while idle.
//   Every register write empties all stacks.
//   Reset: registers return to their defaults and all stacks are empty;
//   the data memory needs no clearing pass and is usable at once.
// ----------------------------------------------------------------------------
module multi_stack_shared_store_core #(
   parameter int STACK_SLOTS = 4,
   parameter int DEPTH       = 128
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              start,
   output logic                              busy,
   input  msss_pkg::req_type                 req_payload,
   // response channel
   output logic                              rsp_valid,
   output msss_pkg::rsp_type                 rsp_payload,
   // configuration port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [msss_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [msss_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [msss_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);

   localparam int FW    = $clog2(DEPTH + 1);
   localparam int AW    = $clog2(DEPTH);
   localparam int NSLOT = (STACK_SLOTS < msss_pkg::MAX_STACKS) ?
                          STACK_SLOTS : msss_pkg::MAX_STACKS;

   msss_pkg::cfg_type    cfg;
   logic                 clear_stacks;
   msss_pkg::state_type  state_ff;
   msss_pkg::state_type  state_in;
   msss_pkg::req_type    req_ff;
   logic                 accept;
   logic                 exec;
   logic [FW-1:0]        fill_ff [NSLOT];
   logic [FW-1:0]        fill_cur;
   logic [FW-1:0]        base;
   logic [FW-1:0]        cap;
   logic                 bad;
   logic                 push_ok;
   logic                 pop_ok;
   logic [FW-1:0]        addr_full;
   logic                 mem_we;
   logic                 mem_re;
   logic [31:0]          rd_data;
   msss_pkg::status_type status_in;
   msss_pkg::status_type status_ff;
   logic                 pop_ok_ff;
   logic                 rsp_valid_ff;
   logic                 fills_empty;

   // configuration registers
   msss_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .cfg          (cfg),
      .clear_stacks (clear_stacks)
   );

   // command sequencer
   assign accept = start & ~busy;
   assign exec   = (state_ff == msss_pkg::ST_EXEC);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msss_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      busy     = 1'b0;
      case (state_ff)
         msss_pkg::ST_IDLE: begin
            if (start) begin
               state_in = msss_pkg::ST_EXEC;
            end
         end
         msss_pkg::ST_EXEC: begin
            busy     = 1'b1;
            state_in = msss_pkg::ST_IDLE;
         end
         default: state_in = msss_pkg::ST_IDLE;
      endcase
   end

   // command capture
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_payload;
      end
   end

   // region bounds of the addressed stack
   msss_region #(
      .DEPTH (DEPTH),
      .NSLOT (NSLOT)
   ) u_region (
      .cfg  (cfg),
      .sel  (req_ff.stack_sel),
      .base (base),
      .cap  (cap),
      .bad  (bad)
   );

   // fill counter of the addressed stack
   always_comb begin
      fill_cur = '0;
      for (int i = 0; i < NSLOT; i++) begin
         if (req_ff.stack_sel == 2'(i)) begin
            fill_cur = fill_ff[i];
         end
      end
   end

   // bounds check and memory address
   always_comb begin
      push_ok   = (req_ff.op == msss_pkg::OP_PUSH) && !bad && (fill_cur < cap);
      pop_ok    = (req_ff.op == msss_pkg::OP_POP) && !bad && (fill_cur != '0);
      addr_full = (req_ff.op == msss_pkg::OP_PUSH) ? (base + fill_cur)
                                                   : (base + fill_cur - FW'(1));
      if (bad) begin
         status_in = msss_pkg::STAT_BAD_STACK;
      end else if (req_ff.op == msss_pkg::OP_PUSH) begin
         status_in = push_ok ? msss_pkg::STAT_OK : msss_pkg::STAT_OVERFLOW;
      end else begin
         status_in = pop_ok ? msss_pkg::STAT_OK : msss_pkg::STAT_UNDERFLOW;
      end
   end

   assign mem_we = exec & push_ok;
   assign mem_re = exec & pop_ok;

   // fill counters: cleared by reset or any register write
   always_ff @(posedge clock) begin
      if (reset || clear_stacks) begin
         for (int i = 0; i < NSLOT; i++) begin
            fill_ff[i] <= '0;
         end
      end else if (exec) begin
         for (int i = 0; i < NSLOT; i++) begin
            if (req_ff.stack_sel == 2'(i)) begin
               if (push_ok) begin
                  fill_ff[i] <= fill_ff[i] + FW'(1);
               end else if (pop_ok) begin
                  fill_ff[i] <= fill_ff[i] - FW'(1);
               end
            end
         end
      end
   end

   // shared data memory
   msss_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .rd_en   (mem_re),
      .addr    (addr_full[AW-1:0]),
      .wr_data (req_ff.push_value),
      .rd_data (rd_data)
   );

   // response beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= exec;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         status_ff <= status_in;
         pop_ok_ff <= pop_ok;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_payload.status    = status_ff;
   assign rsp_payload.pop_value = pop_ok_ff ? $signed(rd_data) : 32'sd0;

   always_comb begin
      fills_empty = 1'b1;
      for (int i = 0; i < NSLOT; i++) begin
         if (fill_ff[i] != '0) begin
            fills_empty = 1'b0;
         end
      end
   end

   // checks
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted command did not enter execute");

   a_exec_rsp: assert property (@(posedge clock) disable iff (reset)
      exec |=> (rsp_valid && !busy))
      else $error("execute cycle not followed by a response beat");

   a_rsp_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !pop_ok_ff) |-> (rsp_payload.pop_value == 32'sd0))
      else $error("non-pop or failed response carries a value");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      clear_stacks |=> fills_empty)
      else $error("register write did not empty the stacks");

   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      (mem_we || mem_re) |-> (addr_full < FW'(DEPTH)))
      else $error("memory access beyond the data store");

endmodule

/* hw/rtl/msss_csr.sv */
// ----------------------------------------------------------------------------
// msss_csr
// APB-style register file: stack count and the first three region sizes.
// Any register write pulses clear_stacks to empty every stack.
// ----------------------------------------------------------------------------
module msss_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [msss_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [msss_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [msss_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready,
   output msss_pkg::cfg_type                 cfg,
   output logic                              clear_stacks
);

   msss_pkg::cfg_type cfg_ff;
   msss_pkg::cfg_type cfg_in;
   logic              wr_beat;
   logic [1:0]        reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign wr_beat = psel & penable & pwrite & pready;

   // next register values
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_beat) begin
         case (reg_idx)
            msss_pkg::REG_STACK_COUNT: cfg_in.stack_count = pwdata[2:0];
            msss_pkg::REG_SIZE_FIRST:  cfg_in.size_first  = pwdata[7:0];
            msss_pkg::REG_SIZE_SECOND: cfg_in.size_second = pwdata[7:0];
            msss_pkg::REG_SIZE_THIRD:  cfg_in.size_third  = pwdata[7:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stack_count <= msss_pkg::RST_STACK_COUNT;
         cfg_ff.size_first  <= msss_pkg::RST_SIZE;
         cfg_ff.size_second <= msss_pkg::RST_SIZE;
         cfg_ff.size_third  <= msss_pkg::RST_SIZE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         msss_pkg::REG_STACK_COUNT: prdata = {29'd0, cfg_ff.stack_count};
         msss_pkg::REG_SIZE_FIRST:  prdata = {24'd0, cfg_ff.size_first};
         msss_pkg::REG_SIZE_SECOND: prdata = {24'd0, cfg_ff.size_second};
         msss_pkg::REG_SIZE_THIRD:  prdata = {24'd0, cfg_ff.size_third};
         default:                   prdata = '0;
      endcase
   end

   assign cfg          = cfg_ff;
   assign clear_stacks = wr_beat;

endmodule

/* hw/rtl/msss_region.sv */
// ----------------------------------------------------------------------------
// msss_region
// Region bounds of the selected stack: base, capacity and the bad-index
// flag, from the configured sizes with boundaries clamped to DEPTH.
// ----------------------------------------------------------------------------
module msss_region #(
   parameter int DEPTH = 128,
   parameter int NSLOT = 4
) (
   input  msss_pkg::cfg_type            cfg,
   input  logic [1:0]                   sel,
   output logic [$clog2(DEPTH+1)-1:0]   base,
   output logic [$clog2(DEPTH+1)-1:0]   cap,
   output logic                         bad
);

   localparam int FW = $clog2(DEPTH + 1);
   localparam int SW = ((FW > 8) ? FW : 8) + 1;

   logic [2:0]    cnt;
   logic [7:0]    sz    [3];
   logic [FW-1:0] b     [msss_pkg::MAX_STACKS];
   logic [FW-1:0] limit [msss_pkg::MAX_STACKS];
   logic [SW-1:0] sum;
   logic [FW-1:0] lim_sel;

   // effective stack count: zero acts as one, saturate at the slot count
   always_comb begin
      cnt = cfg.stack_count;
      if (cnt == 3'd0) begin
         cnt = 3'd1;
      end
      if (cnt > 3'(NSLOT)) begin
         cnt = 3'(NSLOT);
      end
   end

   // running bases, each clamped to DEPTH
   always_comb begin
      sz[0] = cfg.size_first;
      sz[1] = cfg.size_second;
      sz[2] = cfg.size_third;
      b[0]  = '0;
      sum   = '0;
      for (int i = 1; i < msss_pkg::MAX_STACKS; i++) begin
         sum  = SW'(b[i-1]) + SW'(sz[i-1]);
         b[i] = (sum > SW'(DEPTH)) ? FW'(DEPTH) : sum[FW-1:0];
      end
   end

   // limits: next base, or DEPTH for the last active stack
   always_comb begin
      limit[msss_pkg::MAX_STACKS-1] = FW'(DEPTH);
      for (int i = 0; i < msss_pkg::MAX_STACKS - 1; i++) begin
         limit[i] = (3'(i + 1) < cnt) ? b[i+1] : FW'(DEPTH);
      end
   end

   assign base    = b[sel];
   assign lim_sel = limit[sel];
   assign cap     = lim_sel - base;
   assign bad     = ({1'b0, sel} >= cnt);

endmodule

/* hw/rtl/msss_store.sv */
// ----------------------------------------------------------------------------
// msss_store
// Shared data memory: one write or one read per cycle and registered read
// data. Contents are undefined until written.
// ----------------------------------------------------------------------------
module msss_store #(
   parameter int DEPTH = 128
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   addr,
   input  logic [31:0]                wr_data,
   output logic [31:0]                rd_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
